// File: hdl/six_axis_iir_lowpass_with_zeroing_macros.svh
// Assertion helpers for the conditioner RTL.
`ifndef SIX_AXIS_IIR_LOWPASS_WITH_ZEROING_MACROS_SVH
`define SIX_AXIS_IIR_LOWPASS_WITH_ZEROING_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SIXIIR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SIXIIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sixiir_pkg.sv
package sixiir_pkg;

	// Filter shape and zeroing window
	localparam int FILTER_ORDER = 3;
	localparam int AXIS_COUNT   = 6;
	localparam int ZERO_WINDOW  = 100;
	localparam int MAX_AXES     = 6;

	// Field and datapath widths
	localparam int SAMP_W    = 24;
	localparam int COEF_W    = 28;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 60;
	localparam int DLY_W     = 48;
	localparam int CTRL_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int STAT_W    = 2;

	// Coefficient register banks
	localparam int NUM_B = 4;
	localparam int NUM_A = 3;

	// Sequencer sizes
	localparam int NOPS     = 2 * FILTER_ORDER + 1;
	localparam int OP_W     = $clog2(NOPS);
	localparam int AX_W     = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int CNT_W    = $clog2(ZERO_WINDOW + 1);
	localparam int DLY_LEN  = AXIS_COUNT * FILTER_ORDER;
	localparam int NEXT_TAP = (DLY_LEN > 1) ? 1 : 0;

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [DLY_W-1:0]  dly_t;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A3   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL = 3'd7;

	// Control bit positions
	localparam int CTRL_BYPASS = 0;
	localparam int CTRL_AUTO   = 1;

	// Commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_ZERO   = 1'b1;

	// Zero status codes
	localparam logic [STAT_W-1:0] ZS_NONE   = 2'd0;
	localparam logic [STAT_W-1:0] ZS_ACCEPT = 2'd1;
	localparam logic [STAT_W-1:0] ZS_REFUSE = 2'd2;
	localparam logic [STAT_W-1:0] ZS_AUTO   = 2'd3;

	// Reset values of the registers
	localparam coef_t B0_RST = 28'sd1678;
	localparam coef_t B1_RST = 28'sd5033;
	localparam coef_t B2_RST = 28'sd5033;
	localparam coef_t B3_RST = 28'sd1678;
	localparam coef_t A1_RST = -28'sd47764734;
	localparam coef_t A2_RST = 28'sd45399147;
	localparam coef_t A3_RST = -28'sd14394851;
	localparam logic [CTRL_W-1:0] CTRL_RST = 2'd2;

	// Saturate a wide value to the delay width
	function automatic dly_t sat_dly(prod_t v);
		if (v[PROD_W-1:DLY_W-1] == {(PROD_W-DLY_W+1){v[PROD_W-1]}})
			return v[DLY_W-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(DLY_W-1){1'b0}}};
		else
			return {1'b0, {(DLY_W-1){1'b1}}};
	endfunction

	// Saturate a wide value to the feedback width
	function automatic data_t sat_data(prod_t v);
		if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}})
			return v[DATA_W-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// Saturate a wide value to the sample width
	function automatic samp_t sat_samp(prod_t v);
		if (v[PROD_W-1:SAMP_W-1] == {(PROD_W-SAMP_W+1){v[PROD_W-1]}})
			return v[SAMP_W-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(SAMP_W-1){1'b0}}};
		else
			return {1'b0, {(SAMP_W-1){1'b1}}};
	endfunction

	// Saturate a one-bit-grown difference to the sample width
	function automatic samp_t sat_diff(logic signed [SAMP_W:0] v);
		if (v[SAMP_W] == v[SAMP_W-1])
			return v[SAMP_W-1:0];
		else if (v[SAMP_W])
			return {1'b1, {(SAMP_W-1){1'b0}}};
		else
			return {1'b0, {(SAMP_W-1){1'b1}}};
	endfunction

endpackage

// File: hdl/six_axis_iir_lowpass_with_zeroing.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     command, force_x..torque_z
// out      out_valid / out_ready   out_force_x..out_torque_z, zero_status
// cfg      cfg_we (no wait)        cfg_index, cfg_wdata
//
// A filtered sample steps the sequencer through every operation of every axis in turn:
// the one shared 28x32 multiplier issues one product per cycle, seven per axis.
// Bypassed samples and zero requests skip the sequencer. in_ready is high only while idle.
// A finished word waits in the output register; the next word may be taken meanwhile,
// and its last cycle holds until the output register is free.
// Reset clears delays, filtered values, offsets, the sample count and the sequencer.
`include "six_axis_iir_lowpass_with_zeroing_macros.svh"

module six_axis_iir_lowpass_with_zeroing import sixiir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  samp_t                force_x,
	input  samp_t                force_y,
	input  samp_t                force_z,
	input  samp_t                torque_x,
	input  samp_t                torque_y,
	input  samp_t                torque_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output samp_t                out_force_x,
	output samp_t                out_force_y,
	output samp_t                out_force_z,
	output samp_t                out_torque_x,
	output samp_t                out_torque_y,
	output samp_t                out_torque_z,
	output logic [STAT_W-1:0]    zero_status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  coef_t                cfg_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	coef_t             b_q [NUM_B];
	coef_t             a_q [NUM_A];
	logic [CTRL_W-1:0] ctrl_q;

	samp_t             x_in  [MAX_AXES];
	samp_t             x_q   [AXIS_COUNT];
	samp_t             lf_q  [AXIS_COUNT];
	samp_t             off_q [AXIS_COUNT];
	samp_t             out_q [MAX_AXES];
	logic [STAT_W-1:0] status_q;
	logic              out_vld_q;
	logic              cmd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_q;

	dly_t              line_q [DLY_LEN];
	data_t             yf_q;
	prod_t             w_q;
	logic [AX_W-1:0]   ax_q;
	logic [OP_W-1:0]   k_q;

	prod_t             p_s1;
	logic [OP_W-1:0]   p_k_s1;
	logic [AX_W-1:0]   p_ax_s1;
	logic              p_vld_s1;

	logic              in_acc;
	logic              fin_go;

	// Gather the sample fields
	assign x_in[0] = force_x;
	assign x_in[1] = force_y;
	assign x_in[2] = force_z;
	assign x_in[3] = torque_x;
	assign x_in[4] = torque_y;
	assign x_in[5] = torque_z;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign fin_go    = (state_q == ST_FIN) && (!out_vld_q || out_ready);
	assign out_valid = out_vld_q;

	assign out_force_x  = out_q[0];
	assign out_force_y  = out_q[1];
	assign out_force_z  = out_q[2];
	assign out_torque_x = out_q[3];
	assign out_torque_y = out_q[4];
	assign out_torque_z = out_q[5];
	assign zero_status  = status_q;

	// Select multiplier operands: b terms take the sample, a terms the feedback
	logic [OP_W-1:0] b_idx;
	logic [OP_W-1:0] a_idx;
	logic            use_b;
	coef_t           coef_mul;
	data_t           dat_mul;
	prod_t           prod_c;

	always_comb begin
		b_idx    = (k_q + OP_W'(1)) >> 1;
		a_idx    = k_q >> 1;
		use_b    = (k_q == '0) || k_q[0];
		coef_mul = '0;
		if (use_b) begin
			if (int'(b_idx) < NUM_B)
				coef_mul = b_q[b_idx[1:0]];
		end else begin
			if (int'(a_idx) <= NUM_A)
				coef_mul = a_q[a_idx[1:0] - 2'd1];
		end
		dat_mul = use_b ? DATA_W'(x_q[ax_q]) : yf_q;
	end

	assign prod_c = PROD_W'(coef_mul) * PROD_W'(dat_mul);

	// Consume the registered product
	logic  c_acc;
	logic  c_bx;
	logic  c_a;
	logic  c_next;
	prod_t acc_c;
	prod_t next_c;
	prod_t rnd_c;
	data_t yf_c;
	samp_t y_c;
	dly_t  new_dly;

	always_comb begin
		c_acc   = p_vld_s1 && (p_k_s1 == '0);
		c_bx    = p_vld_s1 && p_k_s1[0];
		c_a     = p_vld_s1 && !p_k_s1[0] && (p_k_s1 != '0);
		c_next  = int'(p_k_s1) < (2 * FILTER_ORDER - 1);
		acc_c   = p_s1 + PROD_W'(line_q[0]);
		next_c  = c_next ? PROD_W'(line_q[NEXT_TAP]) : '0;
		rnd_c   = (p_s1 + PROD_W'(1 <<< 7)) >>> 8;
		yf_c    = sat_data((acc_c + PROD_W'(1 <<< 15)) >>> 16);
		y_c     = sat_samp((acc_c + PROD_W'(1 <<< 23)) >>> 24);
		new_dly = sat_dly(w_q - rnd_c);
	end

	// Finish: count, zero decisions and output values
	logic              full_now;
	logic              full_nxt;
	logic              do_auto;
	logic              do_zero;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [STAT_W-1:0] status_c;
	samp_t             out_c [MAX_AXES];

	always_comb begin
		full_now = cnt_q >= CNT_W'(ZERO_WINDOW);
		cnt_nxt  = full_now ? cnt_q : cnt_q + CNT_W'(1);
		full_nxt = cnt_nxt >= CNT_W'(ZERO_WINDOW);
		do_auto  = (cmd_q == CMD_SAMPLE) && full_nxt && pend_q && ctrl_q[CTRL_AUTO];
		do_zero  = (cmd_q == CMD_ZERO) && full_now;
		if (cmd_q == CMD_ZERO)
			status_c = full_now ? ZS_ACCEPT : ZS_REFUSE;
		else
			status_c = do_auto ? ZS_AUTO : ZS_NONE;
		for (int a = 0; a < MAX_AXES; a++) begin
			out_c[a] = '0;
			if (a < AXIS_COUNT && !do_zero)
				out_c[a] = sat_diff((SAMP_W+1)'(lf_q[a]) - (SAMP_W+1)'(off_q[a]));
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q[0] <= B0_RST;
			b_q[1] <= B1_RST;
			b_q[2] <= B2_RST;
			b_q[3] <= B3_RST;
			a_q[0] <= A1_RST;
			a_q[1] <= A2_RST;
			a_q[2] <= A3_RST;
			ctrl_q <= CTRL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:   b_q[0] <= cfg_wdata;
				REG_B1:   b_q[1] <= cfg_wdata;
				REG_B2:   b_q[2] <= cfg_wdata;
				REG_B3:   b_q[3] <= cfg_wdata;
				REG_A1:   a_q[0] <= cfg_wdata;
				REG_A2:   a_q[1] <= cfg_wdata;
				REG_A3:   a_q[2] <= cfg_wdata;
				REG_CTRL: ctrl_q <= cfg_wdata[CTRL_W-1:0];
				default:  ctrl_q <= ctrl_q;
			endcase
		end
	end

	// Sequencer: issue one product per cycle, axis by axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ax_q <= '0;
					k_q  <= '0;
					if (in_acc) begin
						if (command == CMD_ZERO || ctrl_q[CTRL_BYPASS])
							state_q <= ST_FIN;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (int'(k_q) == NOPS - 1) begin
						k_q <= '0;
						if (int'(ax_q) == AXIS_COUNT - 1) begin
							ax_q    <= '0;
							state_q <= ST_FIN;
						end else begin
							ax_q <= ax_q + AX_W'(1);
						end
					end else begin
						k_q <= k_q + OP_W'(1);
					end
				end
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			p_vld_s1 <= 1'b0;
		else
			p_vld_s1 <= (state_q == ST_RUN);
	end

	always_ff @(posedge clk) begin
		p_s1    <= prod_c;
		p_k_s1  <= k_q;
		p_ax_s1 <= ax_q;
	end

	// Capture the sample; hold feedback and partial sums
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			for (int a = 0; a < AXIS_COUNT; a++)
				x_q[a] <= x_in[a];
		end
		if (c_acc)
			yf_q <= yf_c;
		if (c_bx)
			w_q <= p_s1 + next_c;
	end

	// Delay line: advance by one as each new delay is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DLY_LEN; j++)
				line_q[j] <= '0;
		end else if (c_a) begin
			for (int j = 0; j < DLY_LEN - 1; j++)
				line_q[j] <= line_q[j+1];
			line_q[DLY_LEN-1] <= new_dly;
		end
	end

	// Filtered values, offsets, count and auto-zero flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXIS_COUNT; a++) begin
				lf_q[a]  <= '0;
				off_q[a] <= '0;
			end
			cnt_q  <= '0;
			pend_q <= 1'b1;
		end else begin
			if (in_acc && command == CMD_SAMPLE && ctrl_q[CTRL_BYPASS]) begin
				for (int a = 0; a < AXIS_COUNT; a++)
					lf_q[a] <= x_in[a];
			end
			if (c_acc)
				lf_q[p_ax_s1] <= y_c;
			if (fin_go) begin
				if (cmd_q == CMD_SAMPLE)
					cnt_q <= cnt_nxt;
				if (do_zero || do_auto) begin
					for (int a = 0; a < AXIS_COUNT; a++)
						off_q[a] <= lf_q[a];
				end
				if (do_auto)
					pend_q <= 1'b0;
			end
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (fin_go)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			for (int a = 0; a < MAX_AXES; a++)
				out_q[a] <= out_c[a];
			status_q <= status_c;
		end
	end

	`SIXIIR_ASSERT_NEXT(a_run_after_accept, in_acc && command == CMD_SAMPLE && !ctrl_q[CTRL_BYPASS], state_q == ST_RUN, "filtered word did not start the sequencer")
	`SIXIIR_ASSERT_NEXT(a_product_follows_issue, state_q == ST_RUN, p_vld_s1, "issued product was not registered")
	`SIXIIR_ASSERT_SAME(a_auto_clears_pending, out_vld_q && status_q == ZS_AUTO, !pend_q, "auto zero reported while still pending")
	`SIXIIR_ASSERT_SAME(a_accept_needs_full, out_vld_q && status_q == ZS_ACCEPT, cnt_q == CNT_W'(ZERO_WINDOW), "zero accepted before the window filled")

endmodule
